>>> sv/qos_pkg.sv
// Package: shared types and constants for the queue of stacks buffer.
`default_nettype none

package qos_pkg;

   localparam int VALUE_BITS            = 32;
   localparam int ELEMENT_DEPTH_DEFAULT = 64;
   localparam int STACK_SLOTS_DEFAULT   = 16;
   localparam int VALUE_WIDTH_DEFAULT   = 32;

   typedef enum logic [1:0] {
      OP_PUSH    = 2'd0,
      OP_POP     = 2'd1,
      OP_ENQUEUE = 2'd2,
      OP_DEQUEUE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NOTHING     = 2'd1,
      ST_NO_ROOM     = 2'd2,
      ST_EMPTY_STACK = 2'd3
   } status_type;

   typedef struct packed {
      op_type                         operation;
      logic signed [VALUE_BITS-1:0]   value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0]   result_value;
      status_type                     status;
      logic                           last;
   } rsp_type;

endpackage

`default_nettype wire

>>> sv/queue_of_stacks_buffer.sv
// Queue of stacks buffer: build stack, FIFO of sealed stacks, one element store.
// Push and enqueue give no result unless a store is full.
// Pop: one element-store read; its result passes through the staging register into the rsp register.
// Dequeue: read the stack length (S_DQ_LEN), then one value per cycle while the staging
// register is free, from the element store's single read port.
// Reset is synchronous; it clears the state, head pointers, counts and valid flags, the stores are not swept.
`default_nettype none

module queue_of_stacks_buffer #(
   parameter int ELEMENT_DEPTH = qos_pkg::ELEMENT_DEPTH_DEFAULT,
   parameter int STACK_SLOTS   = qos_pkg::STACK_SLOTS_DEFAULT,
   parameter int VALUE_WIDTH   = qos_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire qos_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output qos_pkg::rsp_type      rsp_data
);

   localparam int OutW = qos_pkg::VALUE_BITS;
   localparam int SW   = (VALUE_WIDTH > OutW) ? OutW : VALUE_WIDTH;
   localparam int EAW  = $clog2(ELEMENT_DEPTH);
   localparam int ECW  = $clog2(ELEMENT_DEPTH + 1);
   localparam int ESW  = EAW + 1;
   localparam int QAW  = $clog2(STACK_SLOTS);
   localparam int QCW  = $clog2(STACK_SLOTS + 1);
   localparam int QSW  = QAW + 1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_DQ_LEN = 3'b010,
      S_STREAM = 3'b100
   } state_type;

   typedef struct packed {
      qos_pkg::status_type status;
      logic                last;
   } stg_type;

   logic [SW-1:0]  elem_mem [ELEMENT_DEPTH];
   logic [ECW-1:0] len_mem  [STACK_SLOTS];

   state_type        state_ff, state_in;
   logic [EAW-1:0]   ehead_ff, ehead_in;
   logic [ECW-1:0]   ecount_ff, ecount_in;
   logic [ECW-1:0]   build_ff, build_in;
   logic [QAW-1:0]   qhead_ff, qhead_in;
   logic [QCW-1:0]   qcount_ff, qcount_in;
   logic [ECW-1:0]   remain_ff, remain_in;
   logic [EAW-1:0]   rdptr_ff, rdptr_in;
   logic             stg_valid_ff, stg_valid_in;
   stg_type          stg_ff, stg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   qos_pkg::rsp_type rsp_ff, rsp_in;

   logic [SW-1:0]  mem_rd_ff;
   logic [ECW-1:0] len_rd_ff;

   logic           elem_we, elem_re, len_we, len_re;
   logic [EAW-1:0] elem_waddr, elem_raddr;
   logic [QAW-1:0] len_waddr, len_raddr;

   logic           out_free, stg_move, stg_free, req_fire;
   logic [ESW-1:0] tail_sum, head_sum;
   logic [EAW-1:0] etail, pop_pos, new_head;
   logic [QSW-1:0] qtail_sum;
   logic [QAW-1:0] qtail;
   logic [ECW-1:0] deq_len;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stg_move  = stg_valid_ff && out_free;
   assign stg_free  = !stg_valid_ff || stg_move;
   assign req_ready = (state_ff == S_IDLE) && stg_free;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign tail_sum = ESW'(ehead_ff) + ESW'(ecount_ff);
   assign etail    = (tail_sum >= ESW'(ELEMENT_DEPTH)) ?
                     EAW'(tail_sum - ESW'(ELEMENT_DEPTH)) : EAW'(tail_sum);
   assign pop_pos  = (etail == '0) ? EAW'(ELEMENT_DEPTH - 1) : etail - EAW'(1);

   assign qtail_sum = QSW'(qhead_ff) + QSW'(qcount_ff);
   assign qtail     = (qtail_sum >= QSW'(STACK_SLOTS)) ?
                      QAW'(qtail_sum - QSW'(STACK_SLOTS)) : QAW'(qtail_sum);

   assign deq_len  = (len_rd_ff > ecount_ff) ? ecount_ff : len_rd_ff;
   assign head_sum = ESW'(ehead_ff) + ESW'(deq_len);
   assign new_head = (head_sum >= ESW'(ELEMENT_DEPTH)) ?
                     EAW'(head_sum - ESW'(ELEMENT_DEPTH)) : EAW'(head_sum);

   always_comb begin
      state_in     = state_ff;
      ehead_in     = ehead_ff;
      ecount_in    = ecount_ff;
      build_in     = build_ff;
      qhead_in     = qhead_ff;
      qcount_in    = qcount_ff;
      remain_in    = remain_ff;
      rdptr_in     = rdptr_ff;
      stg_valid_in = stg_valid_ff && !stg_move;
      stg_in       = stg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      elem_we      = 1'b0;
      elem_re      = 1'b0;
      elem_waddr   = etail;
      elem_raddr   = pop_pos;
      len_we       = 1'b0;
      len_re       = 1'b0;
      len_waddr    = qtail;
      len_raddr    = qhead_ff;

      if (stg_move) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = stg_ff.status;
         rsp_in.last         = stg_ff.last;
         rsp_in.result_value = (stg_ff.status == qos_pkg::ST_OK) ? OutW'(mem_rd_ff) : '0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.operation)
                  qos_pkg::OP_PUSH: begin
                     if (ecount_ff == ECW'(ELEMENT_DEPTH)) begin
                        stg_valid_in = 1'b1;
                        stg_in       = '{status: qos_pkg::ST_NO_ROOM, last: 1'b1};
                     end else begin
                        elem_we   = 1'b1;
                        ecount_in = ecount_ff + ECW'(1);
                        build_in  = build_ff + ECW'(1);
                     end
                  end
                  qos_pkg::OP_POP: begin
                     if (build_ff == '0 || ecount_ff == '0) begin
                        stg_valid_in = 1'b1;
                        stg_in       = '{status: qos_pkg::ST_NOTHING, last: 1'b1};
                     end else begin
                        elem_re      = 1'b1;
                        stg_valid_in = 1'b1;
                        stg_in       = '{status: qos_pkg::ST_OK, last: 1'b1};
                        ecount_in    = ecount_ff - ECW'(1);
                        build_in     = build_ff - ECW'(1);
                     end
                  end
                  qos_pkg::OP_ENQUEUE: begin
                     if (qcount_ff == QCW'(STACK_SLOTS)) begin
                        stg_valid_in = 1'b1;
                        stg_in       = '{status: qos_pkg::ST_NO_ROOM, last: 1'b1};
                     end else begin
                        len_we    = 1'b1;
                        qcount_in = qcount_ff + QCW'(1);
                        build_in  = '0;
                     end
                  end
                  qos_pkg::OP_DEQUEUE: begin
                     if (qcount_ff == '0) begin
                        stg_valid_in = 1'b1;
                        stg_in       = '{status: qos_pkg::ST_NOTHING, last: 1'b1};
                     end else begin
                        len_re    = 1'b1;
                        qhead_in  = (qhead_ff == QAW'(STACK_SLOTS - 1)) ?
                                    '0 : qhead_ff + QAW'(1);
                        qcount_in = qcount_ff - QCW'(1);
                        state_in  = S_DQ_LEN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_DQ_LEN: begin
            if (deq_len == '0) begin
               stg_valid_in = 1'b1;
               stg_in       = '{status: qos_pkg::ST_EMPTY_STACK, last: 1'b1};
               state_in     = S_IDLE;
            end else begin
               remain_in = deq_len;
               ehead_in  = new_head;
               ecount_in = ecount_ff - deq_len;
               rdptr_in  = (new_head == '0) ? EAW'(ELEMENT_DEPTH - 1) : new_head - EAW'(1);
               state_in  = S_STREAM;
            end
         end
         S_STREAM: begin
            if (stg_free) begin
               elem_re      = 1'b1;
               elem_raddr   = rdptr_ff;
               stg_valid_in = 1'b1;
               stg_in       = '{status: qos_pkg::ST_OK, last: (remain_ff == ECW'(1))};
               remain_in    = remain_ff - ECW'(1);
               rdptr_in     = (rdptr_ff == '0) ? EAW'(ELEMENT_DEPTH - 1) : rdptr_ff - EAW'(1);
               if (remain_ff == ECW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= req_data.value[SW-1:0];
      end
      if (elem_re) begin
         mem_rd_ff <= elem_mem[elem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= build_ff;
      end
      if (len_re) begin
         len_rd_ff <= len_mem[len_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ehead_ff     <= '0;
         ecount_ff    <= '0;
         build_ff     <= '0;
         qhead_ff     <= '0;
         qcount_ff    <= '0;
         remain_ff    <= '0;
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ehead_ff     <= ehead_in;
         ecount_ff    <= ecount_in;
         build_ff     <= build_in;
         qhead_ff     <= qhead_in;
         qcount_ff    <= qcount_in;
         remain_ff    <= remain_in;
         stg_valid_ff <= stg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rdptr_ff <= rdptr_in;
      stg_ff   <= stg_in;
      rsp_ff   <= rsp_in;
   end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench for the queue of stacks buffer: directed and random requests, a predictor and a result check.
`timescale 1ns / 100ps

module tb_top;
   import qos_pkg::*;

   localparam int DEPTH       = ELEMENT_DEPTH_DEFAULT;
   localparam int SLOTS       = STACK_SLOTS_DEFAULT;
   localparam int VW          = VALUE_WIDTH_DEFAULT;
   localparam int RAND_ITEMS  = 470;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN       = 80;
   localparam int HOLD_CYCLES = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   queue_of_stacks_buffer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // request plan and its count-only shadow, used to steer the stimulus
   req_type request_plan[$];
   int      plan_elems = 0;
   int      plan_build = 0;
   int      plan_lens[$];

   // predicted stack-queue state
   logic [VW-1:0] elem_mem [DEPTH];
   logic [6:0]    len_mem  [SLOTS];
   int            elem_head  = 0;
   int            elem_count = 0;
   int            build_len  = 0;
   int            slot_head  = 0;
   int            slot_count = 0;
   rsp_type       awaited_results[$];

   int   fail_count   = 0;
   int   req_accepted = 0;
   int   cycle_count  = 0;
   int   hold_left    = 0;
   logic hold_done    = 1'b0;
   logic calm;

   assign calm = (req_accepted >= 300) && (req_accepted < 400);

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   task automatic add_item(input op_type op, input logic [31:0] v);
      req_type item;
      int      n;
      item.operation = op;
      item.value     = v;
      request_plan.push_back(item);
      case (op)
         OP_PUSH: begin
            if (plan_elems < DEPTH) begin
               plan_elems++;
               plan_build++;
            end
         end
         OP_POP: begin
            if (plan_build > 0) begin
               plan_elems--;
               plan_build--;
            end
         end
         OP_ENQUEUE: begin
            if (plan_lens.size() < SLOTS) begin
               plan_lens.push_back(plan_build);
               plan_build = 0;
            end
         end
         default: begin
            if (plan_lens.size() > 0) begin
               n = plan_lens.pop_front();
               plan_elems -= n;
            end
         end
      endcase
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(15);
      case (r)
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic random_burst(input int n);
      int r;
      repeat (n) begin
         r = $urandom_range(99);
         if (r < 42)      add_item(OP_PUSH, pick_value());
         else if (r < 57) add_item(OP_POP, pick_value());
         else if (r < 77) add_item(OP_ENQUEUE, pick_value());
         else             add_item(OP_DEQUEUE, pick_value());
      end
   endtask

   // empty the store, then build one stack of full depth and drain it
   task automatic fill_elements();
      while (plan_lens.size() > 0) add_item(OP_DEQUEUE, pick_value());
      while (plan_build > 0) add_item(OP_POP, pick_value());
      while (plan_elems < DEPTH) add_item(OP_PUSH, pick_value());
      add_item(OP_PUSH, pick_value());
      add_item(OP_PUSH, pick_value());
      add_item(OP_POP, pick_value());
      add_item(OP_PUSH, pick_value());
      add_item(OP_ENQUEUE, pick_value());
      add_item(OP_DEQUEUE, pick_value());
      add_item(OP_DEQUEUE, pick_value());
   endtask

   // seal stacks until every slot is used, then drain the queue
   task automatic fill_slots();
      while (plan_lens.size() < SLOTS) begin
         if ($urandom_range(9) < 3 && plan_elems < DEPTH) add_item(OP_PUSH, pick_value());
         add_item(OP_ENQUEUE, pick_value());
      end
      add_item(OP_ENQUEUE, pick_value());
      add_item(OP_ENQUEUE, pick_value());
      while (plan_lens.size() > 0) add_item(OP_DEQUEUE, pick_value());
      add_item(OP_DEQUEUE, pick_value());
   endtask

   function automatic void await_result(input logic [31:0] v, input status_type st,
                                        input logic lst);
      rsp_type r;
      r.result_value = v;
      r.status       = st;
      r.last         = lst;
      awaited_results.push_back(r);
   endfunction

   function automatic void stack_queue_apply(input req_type item);
      logic [31:0] v;
      int          n;
      v = item.value & ({32{1'b1}} >> (32 - VW));
      case (item.operation)
         OP_PUSH: begin
            if (elem_count >= DEPTH) begin
               await_result('0, ST_NO_ROOM, 1'b1);
            end else begin
               elem_mem[(elem_head + elem_count) % DEPTH] = v;
               elem_count++;
               build_len++;
            end
         end
         OP_POP: begin
            if (build_len == 0 || elem_count == 0) begin
               await_result('0, ST_NOTHING, 1'b1);
            end else begin
               await_result(elem_mem[(elem_head + elem_count - 1) % DEPTH], ST_OK, 1'b1);
               elem_count--;
               build_len--;
            end
         end
         OP_ENQUEUE: begin
            if (slot_count >= SLOTS) begin
               await_result('0, ST_NO_ROOM, 1'b1);
            end else begin
               len_mem[(slot_head + slot_count) % SLOTS] = build_len[6:0];
               slot_count++;
               build_len = 0;
            end
         end
         default: begin
            if (slot_count == 0) begin
               await_result('0, ST_NOTHING, 1'b1);
            end else begin
               n = len_mem[slot_head];
               if (n > elem_count) n = elem_count;
               if (n > DEPTH) n = DEPTH;
               slot_head = (slot_head + 1) % SLOTS;
               slot_count--;
               if (n == 0) begin
                  await_result('0, ST_EMPTY_STACK, 1'b1);
               end else begin
                  for (int i = 0; i < n; i++)
                     await_result(elem_mem[(elem_head + n - 1 - i) % DEPTH], ST_OK, i == n - 1);
                  elem_head = (elem_head + n) % DEPTH;
                  elem_count -= n;
               end
            end
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (request_plan.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
            req_valid <= 1'b1;
            req_data  <= request_plan.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off once traffic is flowing
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && req_accepted >= 60) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 19);
      end
   end

   // monitor: predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            stack_queue_apply(req_data);
            req_accepted <= req_accepted + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result with none awaited: value %h status %0d",
                                         rsp_data.result_value, rsp_data.status));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch($sformatf("result_value %h, wanted %h",
                                            rsp_data.result_value, want.result_value));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.last !== want.last)
                  report_mismatch($sformatf("last %0d, wanted %0d",
                                            rsp_data.last, want.last));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int total;
      // directed: empty cases, extremes, every operation
      add_item(OP_POP, 32'h0000_0000);
      add_item(OP_DEQUEUE, 32'hffff_ffff);
      add_item(OP_ENQUEUE, 32'h1234_5678);
      add_item(OP_DEQUEUE, 32'h0000_0000);
      add_item(OP_PUSH, 32'h7fff_ffff);
      add_item(OP_PUSH, 32'h8000_0000);
      add_item(OP_PUSH, 32'h0000_0000);
      add_item(OP_PUSH, 32'hffff_ffff);
      add_item(OP_POP, 32'hffff_ffff);
      add_item(OP_ENQUEUE, 32'hffff_ffff);
      add_item(OP_POP, 32'h5555_5555);
      add_item(OP_PUSH, 32'h5555_5555);
      add_item(OP_PUSH, 32'haaaa_aaaa);
      add_item(OP_ENQUEUE, 32'h0000_0000);
      add_item(OP_PUSH, 32'h0000_0001);
      add_item(OP_DEQUEUE, 32'haaaa_aaaa);
      add_item(OP_DEQUEUE, 32'h5555_5555);
      add_item(OP_POP, 32'h0000_0000);
      add_item(OP_POP, 32'h0000_0000);
      add_item(OP_DEQUEUE, 32'h0000_0000);

      total = request_plan.size() + RAND_ITEMS;
      random_burst(30);
      fill_slots();
      random_burst(20);
      fill_elements();
      while (request_plan.size() < total) begin
         case ($urandom_range(11))
            0:       fill_elements();
            1:       fill_slots();
            default: random_burst($urandom_range(24, 8));
         endcase
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (request_plan.size() > 0 || req_valid) @(posedge clock);
      while (awaited_results.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/qos_pkg.sv
sv/queue_of_stacks_buffer.sv
verif/tb_top.sv
